// ===== rtl/rrsd_pkg.sv =====
// Package: types, constants and field layouts for the RLE RGBA stream decoder.
`default_nettype none

package rrsd_pkg;

  // Largest accepted image width or height.
  localparam int unsigned MAX_DIM = 128;

  // Counter widths; DIM_W and PIX_W are derived from the largest image.
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned PIX_W   = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned RUN_W   = 7;
  localparam int unsigned CNT_W   = (PIX_W > RUN_W) ? PIX_W : RUN_W;
  localparam int unsigned POS_W   = 5;

  // Header constants.
  localparam logic [31:0] MAGIC_WORD = 32'h4764_6B50;
  localparam logic [31:0] TYPE_RLE   = 32'h0201_0002;
  localparam logic [31:0] TYPE_RAW   = 32'h0101_0002;
  localparam logic [31:0] HEADER_MIN = 32'd24;

  // Byte offsets at which a header word is complete, and of the alpha byte within a pixel.
  localparam logic [POS_W-1:0] POS_MAGIC  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(7);
  localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(11);
  localparam logic [POS_W-1:0] POS_WIDTH  = POS_W'(19);
  localparam logic [POS_W-1:0] POS_HEIGHT = POS_W'(23);
  localparam logic [POS_W-1:0] POS_ALPHA  = POS_W'(3);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CTRL,
    PH_PIXEL,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_SHORT_LEN  = 3'd2,
    ST_BAD_TYPE   = 3'd3,
    ST_BAD_SIZE   = 3'd4,
    ST_OVERRUN    = 3'd5
  } status_t;

  // One input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_stream;
  } rrsd_in_t;

  // One result request.
  typedef struct packed {
    logic [31:0]      pixel_rgba;
    logic [RUN_W-1:0] repeat_count;
    logic             end_of_image;
    status_t          status;
  } rrsd_out_t;

endpackage

`default_nettype wire

// ===== rtl/rrsd_core.sv =====
// Decoder state and per-byte step logic: header check, RLE control and pixel assembly.
`default_nettype none

module rrsd_core import rrsd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_en,
  input  wire rrsd_in_t  step_in,
  output logic           res_valid,
  output rrsd_out_t      res
);

  // State registers.
  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [31:0]        hword_r, hword_nxt;
  logic               rle_r, rle_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic [PIX_W-1:0]   pleft_r, pleft_nxt;
  logic [RUN_W-1:0]   rleft_r, rleft_nxt;
  logic               reprun_r, reprun_nxt;
  logic [23:0]        asm_r, asm_nxt;

  // State as seen by this byte: a start marker restarts everything.
  logic               sos;
  logic [7:0]         b;
  phase_t             cur_phase;
  logic [POS_W-1:0]   cur_pos;
  logic [31:0]        cur_hword;
  logic               cur_rle;
  logic [DIM_W-1:0]   cur_width;
  logic [PIX_W-1:0]   cur_pleft;
  logic [RUN_W-1:0]   cur_rleft;
  logic               cur_reprun;
  logic [23:0]        cur_asm;

  // Derived step values.
  logic [31:0]        hword_new;
  logic               dim_ok;
  logic               hdr_err;
  status_t            hdr_st;
  logic [CNT_W-1:0]   pl_ext, rl_ext, rep_ext, pl_new_ext;
  logic               rl_lt;
  logic [RUN_W-1:0]   rep;
  logic [RUN_W-1:0]   rl_new;
  logic [PIX_W-1:0]   pl_new;
  logic               over;
  logic               pix_last_byte;
  logic [2*DIM_W-1:0] area;

  assign sos        = step_in.start_of_stream;
  assign b          = step_in.data_byte;
  assign cur_phase  = sos ? PH_HEADER : phase_r;
  assign cur_pos    = sos ? '0 : pos_r;
  assign cur_hword  = sos ? '0 : hword_r;
  assign cur_rle    = sos ? 1'b0 : rle_r;
  assign cur_width  = sos ? '0 : width_r;
  assign cur_pleft  = sos ? '0 : pleft_r;
  assign cur_rleft  = sos ? '0 : rleft_r;
  assign cur_reprun = sos ? 1'b0 : reprun_r;
  assign cur_asm    = sos ? '0 : asm_r;

  // Header word shift and checks on the word completed by this byte.
  always_comb begin
    hword_new = {cur_hword[23:0], b};
    dim_ok    = (hword_new >= 32'd1) && (hword_new <= 32'(MAX_DIM));
    hdr_err   = 1'b0;
    hdr_st    = ST_OK;
    case (cur_pos)
      POS_MAGIC: begin
        if (hword_new != MAGIC_WORD) begin
          hdr_err = 1'b1;
          hdr_st  = ST_BAD_MAGIC;
        end
      end
      POS_LENGTH: begin
        if (hword_new < HEADER_MIN) begin
          hdr_err = 1'b1;
          hdr_st  = ST_SHORT_LEN;
        end
      end
      POS_TYPE: begin
        if (hword_new != TYPE_RLE && hword_new != TYPE_RAW) begin
          hdr_err = 1'b1;
          hdr_st  = ST_BAD_TYPE;
        end
      end
      POS_WIDTH, POS_HEIGHT: begin
        if (!dim_ok) begin
          hdr_err = 1'b1;
          hdr_st  = ST_BAD_SIZE;
        end
      end
      default: begin
        hdr_err = 1'b0;
      end
    endcase
    area = cur_width * hword_new[DIM_W-1:0];
  end

  // Pixel count arithmetic for a completed pixel.
  always_comb begin
    pix_last_byte = (cur_pos == POS_ALPHA);
    pl_ext  = CNT_W'(cur_pleft);
    rl_ext  = CNT_W'(cur_rleft);
    rl_lt   = rl_ext < pl_ext;
    rep_ext = '0;
    rl_new  = cur_rleft;
    over    = 1'b0;
    if (!cur_rle) begin
      rep_ext = CNT_W'(1);
    end else if (cur_reprun) begin
      rep_ext = rl_lt ? rl_ext : pl_ext;
      over    = rl_ext > pl_ext;
      rl_new  = '0;
    end else begin
      rep_ext = CNT_W'(1);
      rl_new  = (cur_rleft != '0) ? cur_rleft - RUN_W'(1) : cur_rleft;
      // A literal run that still has pixels when the image ends is an overrun.
      over    = (pl_ext == CNT_W'(1)) && (rl_new != '0);
    end
    pl_new_ext = pl_ext - rep_ext;
    pl_new     = pl_new_ext[PIX_W-1:0];
    rep        = rep_ext[RUN_W-1:0];
  end

  // Next phase.
  always_comb begin
    phase_nxt = cur_phase;
    case (cur_phase)
      PH_HEADER: begin
        if (hdr_err) begin
          phase_nxt = PH_DONE;
        end else if (cur_pos == POS_HEIGHT) begin
          phase_nxt = cur_rle ? PH_CTRL : PH_PIXEL;
        end
      end
      PH_CTRL: begin
        if (b[RUN_W-1:0] != '0) begin
          phase_nxt = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (pix_last_byte) begin
          if (cur_pleft == '0 || pl_new == '0) begin
            phase_nxt = PH_DONE;
          end else if (cur_rle && rl_new == '0) begin
            phase_nxt = PH_CTRL;
          end
        end
      end
      default: begin
        phase_nxt = cur_phase;
      end
    endcase
  end

  // Data state updates and the result.
  always_comb begin
    pos_nxt    = cur_pos;
    hword_nxt  = cur_hword;
    rle_nxt    = cur_rle;
    width_nxt  = cur_width;
    height_nxt = sos ? '0 : height_r;
    pleft_nxt  = cur_pleft;
    rleft_nxt  = cur_rleft;
    reprun_nxt = cur_reprun;
    asm_nxt    = cur_asm;
    res_valid  = 1'b0;
    res        = '{pixel_rgba: '0, repeat_count: '0, end_of_image: 1'b0, status: ST_OK};
    case (cur_phase)
      PH_HEADER: begin
        hword_nxt = hword_new;
        pos_nxt   = cur_pos + POS_W'(1);
        if (hdr_err) begin
          res_valid        = 1'b1;
          res.end_of_image = 1'b1;
          res.status       = hdr_st;
        end else begin
          if (cur_pos == POS_TYPE) begin
            rle_nxt = (hword_new == TYPE_RLE);
          end
          if (cur_pos == POS_WIDTH) begin
            width_nxt = hword_new[DIM_W-1:0];
          end
          if (cur_pos == POS_HEIGHT) begin
            height_nxt = hword_new[DIM_W-1:0];
            pleft_nxt  = PIX_W'(area);
            pos_nxt    = '0;
            asm_nxt    = '0;
            rleft_nxt  = '0;
            reprun_nxt = 1'b0;
          end
        end
      end
      PH_CTRL: begin
        if (b[RUN_W-1:0] != '0) begin
          rleft_nxt  = b[RUN_W-1:0];
          reprun_nxt = b[7];
          pos_nxt    = '0;
          asm_nxt    = '0;
        end
      end
      PH_PIXEL: begin
        if (!pix_last_byte) begin
          case (cur_pos[1:0])
            2'd0:    asm_nxt[7:0]   = b;
            2'd1:    asm_nxt[15:8]  = b;
            default: asm_nxt[23:16] = b;
          endcase
          pos_nxt = cur_pos + POS_W'(1);
        end else begin
          pos_nxt   = '0;
          asm_nxt   = '0;
          res_valid = 1'b1;
          if (cur_pleft == '0) begin
            res.end_of_image = 1'b1;
            res.status       = ST_OVERRUN;
          end else begin
            pleft_nxt        = pl_new;
            rleft_nxt        = rl_new;
            res.pixel_rgba   = {b, cur_asm};
            res.repeat_count = rep;
            if (pl_new == '0) begin
              res.end_of_image = 1'b1;
              res.status       = over ? ST_OVERRUN : ST_OK;
            end
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // State update once per accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      hword_r  <= '0;
      rle_r    <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      pleft_r  <= '0;
      rleft_r  <= '0;
      reprun_r <= 1'b0;
      asm_r    <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      hword_r  <= hword_nxt;
      rle_r    <= rle_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      pleft_r  <= pleft_nxt;
      rleft_r  <= rleft_nxt;
      reprun_r <= reprun_nxt;
      asm_r    <= asm_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rle_rgba_image_stream_decoder.sv =====
// Top level of the RLE RGBA image stream decoder: input register, decoder core, result register.
`default_nettype none

// The decoder takes one stream byte per cycle and gives at most one result per byte. A byte
// passes an input register, one step of header, control or pixel logic, and a result register.
// With out_ready held high the sustained rate is one byte every cycle; a stalled result register
// holds the input register, and in_ready then follows out_ready. Raise start_of_stream on the
// first header byte; it abandons any image in progress. Header errors end the image with a
// status-only result (repeat_count 0, end_of_image 1).
module rle_rgba_image_stream_decoder import rrsd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rrsd_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rrsd_out_t      out_data
);

  logic      in_vld_r;
  rrsd_in_t  in_req_r;
  logic      out_vld_r;
  rrsd_out_t out_req_r;
  logic      out_free;
  logic      advance;
  logic      res_valid;
  rrsd_out_t res;

  // Handshake: the input stage moves on whenever the result register can take a request.
  assign out_free  = !out_vld_r || out_ready;
  assign advance   = in_vld_r && out_free;
  assign in_ready  = !in_vld_r || out_free;
  assign out_valid = out_vld_r;
  assign out_data  = out_req_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r <= in_data;
    end
  end

  // Decoder step.
  rrsd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .step_in   (in_req_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_req_r <= res;
    end
  end

  // Any non-ok status closes the image.
  a_err_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid && res.status != ST_OK) |-> res.end_of_image)
    else $error("error status without end of image");

  // A zero repeat count only appears on a failing status-only result.
  a_zero_rep_is_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_req_r.repeat_count == '0) |->
      (out_req_r.end_of_image && out_req_r.status != ST_OK))
    else $error("zero repeat count on a pixel result");

  // A blocked input stage keeps its request.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_free) |=> (in_vld_r && $stable(in_req_r)))
    else $error("input stage lost a request while blocked");

  // The result register never drops an unaccepted request.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(out_req_r)))
    else $error("result register changed while stalled");

endmodule

`default_nettype wire

// ===== bench/rle_rgba_image_stream_decoder_tb.sv =====
// Self-checking testbench for the RLE RGBA image stream decoder, with a scoreboard class.
module rle_rgba_image_stream_decoder_tb;
  import rrsd_pkg::*;

  localparam int unsigned PHASE_ITEMS  = 300;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Ways in which a generated header can be broken.
  typedef enum int {
    HDR_GOOD,
    HDR_MAGIC,
    HDR_LENGTH,
    HDR_TYPE,
    HDR_WIDTH,
    HDR_HEIGHT
  } hdr_fault_e;

  // Decodes the accepted byte stream on its own and checks each result request against it.
  class pixel_scoreboard;
    rrsd_out_t   expected_pixels[$];
    int unsigned errors;
    phase_t      phase;
    logic [4:0]  byte_pos;
    logic [31:0] hdr_word;
    bit          rle_mode;
    int unsigned img_width;
    int unsigned img_height;
    int unsigned pixels_left;
    int unsigned run_left;
    bit          repeat_run;
    logic [23:0] pixel_bytes;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase       = PH_IDLE;
      byte_pos    = '0;
      hdr_word    = '0;
      rle_mode    = 1'b0;
      img_width   = 0;
      img_height  = 0;
      pixels_left = 0;
      run_left    = 0;
      repeat_run  = 1'b0;
      pixel_bytes = '0;
    endfunction

    function void queue_result(logic [31:0] pix, int unsigned rep, bit eoi, status_t st);
      rrsd_out_t r;
      r.pixel_rgba   = pix;
      r.repeat_count = RUN_W'(rep);
      r.end_of_image = eoi;
      r.status       = st;
      expected_pixels.push_back(r);
    endfunction

    // An error ends the image with a status-only result.
    function void abort_image(status_t st);
      queue_result(32'd0, 0, 1'b1, st);
      phase = PH_DONE;
    endfunction

    // Advances the decode by one accepted input request.
    function void note_byte(rrsd_in_t req);
      logic [4:0]  word_end;
      logic [31:0] pix;
      int unsigned rep;
      bit          over;
      if (req.start_of_stream) begin
        clear_state();
        phase = PH_HEADER;
      end
      case (phase)
        PH_HEADER: begin
          hdr_word = {hdr_word[23:0], req.data_byte};
          word_end = byte_pos;
          byte_pos = byte_pos + 5'd1;
          if (word_end == POS_MAGIC && hdr_word != MAGIC_WORD) begin
            abort_image(ST_BAD_MAGIC);
          end else if (word_end == POS_LENGTH && hdr_word < HEADER_MIN) begin
            abort_image(ST_SHORT_LEN);
          end else if (word_end == POS_TYPE) begin
            if (hdr_word == TYPE_RLE) rle_mode = 1'b1;
            else if (hdr_word == TYPE_RAW) rle_mode = 1'b0;
            else abort_image(ST_BAD_TYPE);
          end else if (word_end == POS_WIDTH || word_end == POS_HEIGHT) begin
            if (hdr_word == 0 || hdr_word > MAX_DIM) begin
              abort_image(ST_BAD_SIZE);
            end else if (word_end == POS_WIDTH) begin
              img_width = hdr_word;
            end else begin
              // Header complete: set up the body.
              img_height  = hdr_word;
              pixels_left = img_width * img_height;
              byte_pos    = '0;
              pixel_bytes = '0;
              run_left    = 0;
              repeat_run  = 1'b0;
              phase       = rle_mode ? PH_CTRL : PH_PIXEL;
            end
          end
        end
        PH_CTRL: begin
          // A control byte with a zero count is skipped.
          if (req.data_byte[6:0] != 7'd0) begin
            run_left    = req.data_byte[6:0];
            repeat_run  = req.data_byte[7];
            byte_pos    = '0;
            pixel_bytes = '0;
            phase       = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          if (byte_pos < 5'd3) begin
            pixel_bytes[8*byte_pos +: 8] = req.data_byte;
            byte_pos = byte_pos + 5'd1;
          end else begin
            pix         = {req.data_byte, pixel_bytes};
            byte_pos    = '0;
            pixel_bytes = '0;
            if (pixels_left == 0) begin
              abort_image(ST_OVERRUN);
            end else begin
              if (!rle_mode) begin
                rep = 1;
                pixels_left--;
                over = 1'b0;
              end else if (repeat_run) begin
                // Repeat runs are clipped to the pixels that remain.
                rep = (run_left < pixels_left) ? run_left : pixels_left;
                over = run_left > rep;
                pixels_left -= rep;
                run_left = 0;
              end else begin
                rep = 1;
                if (run_left > 0) run_left--;
                pixels_left--;
                over = (pixels_left == 0 && run_left > 0);
              end
              if (pixels_left == 0) begin
                phase = PH_DONE;
                queue_result(pix, rep, 1'b1, over ? ST_OVERRUN : ST_OK);
              end else begin
                if (rle_mode && run_left == 0) phase = PH_CTRL;
                queue_result(pix, rep, 1'b0, ST_OK);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted result request with the oldest expectation.
    function void check_result(rrsd_out_t got);
      rrsd_out_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pixel/repeat/end/status %h/%0d/%0b/%0d",
                 $time, got.pixel_rgba, got.repeat_count, got.end_of_image, got.status);
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_rgba !== want.pixel_rgba || got.repeat_count !== want.repeat_count ||
            got.end_of_image !== want.end_of_image || got.status !== want.status) begin
          errors++;
          $display("%0t: pixel/repeat/end/status expected %h/%0d/%0b/%0d, actual %h/%0d/%0b/%0d",
                   $time, want.pixel_rgba, want.repeat_count, want.end_of_image, want.status,
                   got.pixel_rgba, got.repeat_count, got.end_of_image, got.status);
        end
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  rrsd_in_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  rrsd_out_t out_data;

  pixel_scoreboard sb = new();
  rrsd_in_t        stream_bytes[$];
  int unsigned     send_idle_pct = 13;
  int unsigned     recv_idle_pct = 64;
  int unsigned     hold_asks     = 0;
  int unsigned     stall_cycles  = 0;

  rle_rgba_image_stream_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Both channels are sampled before any update of this edge lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_byte(in_data);
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off when one is asked for.
  initial begin : result_sink
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_asks) begin
        holds_done++;
        repeat (LONG_HOLD) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one input request and waits until it is accepted.
  task automatic send_req(input rrsd_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_stream();
    while (stream_bytes.size() != 0) send_req(stream_bytes.pop_front());
  endtask

  task automatic put_byte(input logic [7:0] b, input bit sos);
    stream_bytes.push_back(rrsd_in_t'{data_byte: b, start_of_stream: sos});
  endtask

  // Header words are big-endian.
  task automatic put_word(input logic [31:0] w, input bit sos);
    put_byte(w[31:24], sos);
    put_byte(w[23:16], 1'b0);
    put_byte(w[15:8], 1'b0);
    put_byte(w[7:0], 1'b0);
  endtask

  // Pixels go out red first.
  task automatic put_pixel(input logic [31:0] px);
    put_byte(px[7:0], 1'b0);
    put_byte(px[15:8], 1'b0);
    put_byte(px[23:16], 1'b0);
    put_byte(px[31:24], 1'b0);
  endtask

  function automatic logic [31:0] random_pixel();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] bad_dim();
    case ($urandom_range(2))
      0: return 32'd0;
      1: return MAX_DIM + 1;
      default: return $urandom | 32'h0000_0100;
    endcase
  endfunction

  task automatic put_header(input hdr_fault_e fault, input bit rle_body,
                            input logic [31:0] w, input logic [31:0] h);
    logic [31:0] kind;
    kind = rle_body ? TYPE_RLE : TYPE_RAW;
    if (fault == HDR_TYPE) kind = $urandom_range(1) ? kind ^ (32'd1 << $urandom_range(31)) : $urandom;
    put_word((fault == HDR_MAGIC) ? MAGIC_WORD ^ (32'd1 << $urandom_range(31)) : MAGIC_WORD, 1'b1);
    if (fault == HDR_LENGTH) put_word($urandom_range(HEADER_MIN - 1), 1'b0);
    else if ($urandom_range(2) == 0) put_word(HEADER_MIN, 1'b0);
    else put_word($urandom_range(32'hFFFF_FFFF, HEADER_MIN), 1'b0);
    put_word(kind, 1'b0);
    // Rowstride is not checked by the block.
    put_word($urandom, 1'b0);
    put_word((fault == HDR_WIDTH) ? bad_dim() : w, 1'b0);
    put_word((fault == HDR_HEIGHT) ? bad_dim() : h, 1'b0);
  endtask

  task automatic put_raw_body(input int unsigned pixels);
    repeat (pixels) put_pixel(random_pixel());
  endtask

  // Mix of repeat runs, literal runs, zero-count controls and runs past the image end.
  task automatic put_rle_body(input int unsigned pixels);
    int unsigned left_px, cnt, span, pick, cap;
    bit          is_rep;
    left_px = pixels;
    while (left_px > 0) begin
      pick   = $urandom_range(99);
      is_rep = $urandom_range(1);
      if (pick < 6) begin
        put_byte(is_rep ? 8'h80 : 8'h00, 1'b0);
      end else begin
        if (pick < 16) begin
          cnt = $urandom_range(1) ? 127 : left_px + $urandom_range(8, 1);
          if (cnt > 127) cnt = 127;
        end else if (is_rep) begin
          cap = (left_px < 127) ? left_px : 127;
          cnt = ($urandom_range(3) == 0) ? cap : $urandom_range(cap, 1);
        end else begin
          cap = (left_px < 6) ? left_px : 6;
          cnt = $urandom_range(cap, 1);
        end
        span = (cnt < left_px) ? cnt : left_px;
        put_byte({is_rep, 7'(cnt)}, 1'b0);
        if (is_rep) put_pixel(random_pixel());
        else put_raw_body(span);
        left_px -= span;
      end
    end
  endtask

  // One random image: mostly well formed, some broken headers, some cut short.
  task automatic put_random_image();
    int unsigned pick, w, h;
    bit          rle_body;
    hdr_fault_e  fault;
    pick     = $urandom_range(99);
    rle_body = (pick < 45) || (pick >= 70 && $urandom_range(1));
    w        = $urandom_range(4, 1);
    h        = $urandom_range(4, 1);
    if (rle_body && $urandom_range(5) == 0) begin
      if ($urandom_range(1)) begin
        w = MAX_DIM;
        h = $urandom_range(2, 1);
      end else begin
        w = 1;
        h = MAX_DIM;
      end
    end
    if (pick < 70 || pick >= 92) begin
      put_header(HDR_GOOD, rle_body, w, h);
      if (rle_body) put_rle_body(w * h);
      else put_raw_body(w * h);
      // A cut image is abandoned by the next start.
      if (pick >= 92) repeat ($urandom_range(12, 1)) void'(stream_bytes.pop_back());
    end else if (pick < 85) begin
      fault = hdr_fault_e'($urandom_range(HDR_HEIGHT, HDR_MAGIC));
      put_header(fault, rle_body, w, h);
    end else begin
      // Largest image, abandoned after a few full-length repeat runs.
      put_header(HDR_GOOD, 1'b1, MAX_DIM, MAX_DIM);
      repeat ($urandom_range(3, 1)) begin
        put_byte(8'hFF, 1'b0);
        put_pixel(random_pixel());
      end
    end
  endtask

  // Reset, directed requests, then three phases of random images.
  initial begin : stimulus
    int unsigned body_items;
    body_items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bytes before any start are dropped; then bad magic, short length and bad type.
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_word(MAGIC_WORD ^ 32'h0000_0001, 1'b1);
    put_word(MAGIC_WORD, 1'b1);
    put_word(HEADER_MIN - 1, 1'b0);
    put_word(MAGIC_WORD, 1'b1);
    put_word(HEADER_MIN, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b0);
    send_stream();

    for (int unsigned p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Long result stall while a raw image keeps coming in.
          hold_asks++;
          put_header(HDR_GOOD, 1'b0, 4, 4);
          put_raw_body(16);
          send_stream();
        end
      endcase
      while (body_items < (p + 1) * PHASE_ITEMS) begin
        put_random_image();
        body_items += stream_bytes.size();
        // Trailing noise, now and then with a stray start.
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(4, 1)) put_byte(8'($urandom), $urandom_range(15) == 0);
        end
        send_stream();
      end
    end
    in_valid <= 1'b0;

    // Drain the outstanding results.
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
